/* sv/csab_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csab_pkg
// Shared types, constants and the per-channel blend for the sprite blitter.
// ----------------------------------------------------------------------------
package csab_pkg;

    // Default parameter values
    localparam int SCREEN_DIM_DEF = 4096;
    localparam int SPRITE_DIM_DEF = 1024;

    // Fixed field widths
    localparam int SCR_CFG_W = 13;
    localparam int SPR_CFG_W = 11;
    localparam int POS_W     = 13;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 13;
    localparam int COLOR_W   = 32;
    localparam int ADDR_W    = 24;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_X         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_Y         = 3'd5;

    // Register reset values
    localparam logic [SCR_CFG_W-1:0] SCREEN_WIDTH_RST  = 13'd1280;
    localparam logic [SCR_CFG_W-1:0] SCREEN_HEIGHT_RST = 13'd720;
    localparam logic [SPR_CFG_W-1:0] SPRITE_WIDTH_RST  = 11'd32;
    localparam logic [SPR_CFG_W-1:0] SPRITE_HEIGHT_RST = 11'd32;
    localparam logic [POS_W-1:0]     POS_RST           = 13'd0;

    localparam logic [7:0] ALPHA_ZERO   = 8'h00;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // Control word passed from the clip stage to the blend stage
    typedef struct packed {
        logic valid;
        logic we;
        logic last;
    } ctl_t;

    // (s*a + d*(255-a)) / 255, truncated. Division by 255 done as
    // (v + 1 + (v >> 8)) >> 8, exact for every 16-bit v reached here.
    function automatic logic [7:0] blend_chan(
        input logic [7:0] s,
        input logic [7:0] d,
        input logic [7:0] a
    );
        logic [15:0] sum;
        logic [16:0] adj;
        begin
            sum = (16'(s) * 16'(a)) + (16'(d) * 16'(ALPHA_OPAQUE - a));
            adj = 17'(sum) + 17'd1 + 17'(sum[15:8]);
            blend_chan = adj[15:8];
        end
    endfunction

endpackage
`default_nettype wire

/* sv/csab_clip.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csab_clip
// Sprite column/row counters, screen clipping and the first pipeline register.
// ----------------------------------------------------------------------------
module csab_clip #(
    parameter int MAX_SCREEN_DIM = 4096,
    parameter int MAX_SPRITE_DIM = 1024
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              accept,
    input  wire logic                              take,
    input  wire logic [csab_pkg::SCR_CFG_W-1:0]    screen_width,
    input  wire logic [csab_pkg::SCR_CFG_W-1:0]    screen_height,
    input  wire logic [csab_pkg::SPR_CFG_W-1:0]    sprite_width,
    input  wire logic [csab_pkg::SPR_CFG_W-1:0]    sprite_height,
    input  wire logic signed [csab_pkg::POS_W-1:0] pos_x,
    input  wire logic signed [csab_pkg::POS_W-1:0] pos_y,
    input  wire logic [csab_pkg::COLOR_W-1:0]      sprite_pixel,
    input  wire logic [csab_pkg::COLOR_W-1:0]      frame_pixel,
    output csab_pkg::ctl_t                         a_ctl,
    output logic [$clog2(MAX_SCREEN_DIM)-1:0]      a_x,
    output logic [$clog2(MAX_SCREEN_DIM)-1:0]      a_y,
    output logic [$clog2(MAX_SCREEN_DIM+1)-1:0]    a_scw,
    output logic [csab_pkg::COLOR_W-1:0]           a_src,
    output logic [csab_pkg::COLOR_W-1:0]           a_dst
);
    import csab_pkg::*;

    localparam int CNT_W   = $clog2(MAX_SPRITE_DIM);
    localparam int SDIM_W  = CNT_W + 1;
    localparam int SCMP_W  = (SDIM_W > SPR_CFG_W) ? SDIM_W : SPR_CFG_W;
    localparam int COORD_W = $clog2(MAX_SCREEN_DIM);
    localparam int DIM_W   = $clog2(MAX_SCREEN_DIM + 1);
    localparam int DCMP_W  = (DIM_W > SCR_CFG_W) ? DIM_W : SCR_CFG_W;
    localparam int X_W     = ((POS_W > CNT_W + 1) ? POS_W : CNT_W + 1) + 1;
    localparam int XC_W    = (X_W > DIM_W) ? X_W : DIM_W;

    logic [CNT_W-1:0]  col_reg, col_next;
    logic [CNT_W-1:0]  row_reg, row_next;

    logic [SCMP_W-1:0] sw_ext, sh_ext;
    logic [SDIM_W-1:0] sw, sh;
    logic [DCMP_W-1:0] scw_ext, sch_ext;
    logic [DIM_W-1:0]  scw, sch;
    logic [CNT_W-1:0]  col_eff, row_eff;
    logic [SDIM_W-1:0] col_inc, row_inc;
    logic              end_row, end_sprite;
    logic signed [X_W-1:0] x_s, y_s;
    logic              on_screen;

    ctl_t              ctl_reg, ctl_next;

    logic [COORD_W-1:0] a_x_reg;
    logic [COORD_W-1:0] a_y_reg;
    logic [DIM_W-1:0]   a_scw_reg;
    logic [COLOR_W-1:0] a_src_reg;
    logic [COLOR_W-1:0] a_dst_reg;

    // Size clamping: sprite 0 acts as 1, both saturate at their maximum
    always_comb
    begin
        sw_ext  = SCMP_W'(sprite_width);
        sh_ext  = SCMP_W'(sprite_height);
        if (sw_ext == '0)
            sw = SDIM_W'(1);
        else if (sw_ext > SCMP_W'(MAX_SPRITE_DIM))
            sw = SDIM_W'(MAX_SPRITE_DIM);
        else
            sw = SDIM_W'(sw_ext);
        if (sh_ext == '0)
            sh = SDIM_W'(1);
        else if (sh_ext > SCMP_W'(MAX_SPRITE_DIM))
            sh = SDIM_W'(MAX_SPRITE_DIM);
        else
            sh = SDIM_W'(sh_ext);

        scw_ext = DCMP_W'(screen_width);
        sch_ext = DCMP_W'(screen_height);
        scw = (scw_ext > DCMP_W'(MAX_SCREEN_DIM)) ? DIM_W'(MAX_SCREEN_DIM)
                                                  : DIM_W'(scw_ext);
        sch = (sch_ext > DCMP_W'(MAX_SCREEN_DIM)) ? DIM_W'(MAX_SCREEN_DIM)
                                                  : DIM_W'(sch_ext);
    end

    // Counters; a counter past a shrunk size is pulled back to the edge
    always_comb
    begin
        col_eff = (SDIM_W'(col_reg) >= sw) ? CNT_W'(sw - SDIM_W'(1)) : col_reg;
        row_eff = (SDIM_W'(row_reg) >= sh) ? CNT_W'(sh - SDIM_W'(1)) : row_reg;
        col_inc = SDIM_W'(col_eff) + SDIM_W'(1);
        row_inc = SDIM_W'(row_eff) + SDIM_W'(1);
        end_row    = col_inc >= sw;
        end_sprite = end_row && (row_inc >= sh);

        if (end_row)
        begin
            col_next = '0;
            row_next = end_sprite ? '0 : row_inc[CNT_W-1:0];
        end
        else
        begin
            col_next = col_inc[CNT_W-1:0];
            row_next = row_eff;
        end
    end

    // Screen position and clip test
    always_comb
    begin
        x_s = X_W'(pos_x) + $signed(X_W'(col_eff));
        y_s = X_W'(pos_y) + $signed(X_W'(row_eff));
        on_screen = !x_s[X_W-1] && !y_s[X_W-1]
                 && (XC_W'($unsigned(x_s)) < XC_W'(scw))
                 && (XC_W'($unsigned(y_s)) < XC_W'(sch));

        ctl_next = ctl_reg;
        if (accept)
        begin
            ctl_next.valid = 1'b1;
            ctl_next.we    = on_screen && (sprite_pixel[31:24] != ALPHA_ZERO);
            ctl_next.last  = end_sprite;
        end
        else if (take)
        begin
            ctl_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_x_reg   <= x_s[COORD_W-1:0];
            a_y_reg   <= y_s[COORD_W-1:0];
            a_scw_reg <= scw;
            a_src_reg <= sprite_pixel;
            a_dst_reg <= frame_pixel;
        end
    end

    assign a_ctl = ctl_reg;
    assign a_x   = a_x_reg;
    assign a_y   = a_y_reg;
    assign a_scw = a_scw_reg;
    assign a_src = a_src_reg;
    assign a_dst = a_dst_reg;

endmodule
`default_nettype wire

/* sv/csab_blend.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csab_blend
// Address multiply, alpha blend and the output register.
// ----------------------------------------------------------------------------
module csab_blend #(
    parameter int MAX_SCREEN_DIM = 4096
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire csab_pkg::ctl_t                 a_ctl,
    input  wire logic [$clog2(MAX_SCREEN_DIM)-1:0]   a_x,
    input  wire logic [$clog2(MAX_SCREEN_DIM)-1:0]   a_y,
    input  wire logic [$clog2(MAX_SCREEN_DIM+1)-1:0] a_scw,
    input  wire logic [csab_pkg::COLOR_W-1:0]   a_src,
    input  wire logic [csab_pkg::COLOR_W-1:0]   a_dst,
    input  wire logic                           out_stall,
    output logic                                take,
    output logic                                out_valid,
    output logic                                write_enable,
    output logic [csab_pkg::ADDR_W-1:0]         dest_address,
    output logic [csab_pkg::COLOR_W-1:0]        out_color,
    output logic                                last
);
    import csab_pkg::*;

    localparam int COORD_W = $clog2(MAX_SCREEN_DIM);
    localparam int DIM_W   = $clog2(MAX_SCREEN_DIM + 1);
    localparam int PROD_W  = COORD_W + DIM_W + 1;
    localparam int AC_W    = (PROD_W > ADDR_W) ? PROD_W : ADDR_W;

    logic              valid_reg;
    logic [AC_W-1:0]   lin;
    logic [7:0]        alpha;
    logic [ADDR_W-1:0] addr_next;
    logic [COLOR_W-1:0] color_next;

    logic               we_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [COLOR_W-1:0] color_reg;
    logic               last_reg;

    assign take = a_ctl.valid && (!valid_reg || !out_stall);

    always_comb
    begin
        alpha = a_src[31:24];
        lin   = AC_W'(a_y) * AC_W'(a_scw) + AC_W'(a_x);
        addr_next  = '0;
        color_next = '0;
        if (a_ctl.we)
        begin
            addr_next = lin[ADDR_W-1:0];
            if (alpha == ALPHA_OPAQUE)
                color_next = a_src;
            else
                color_next = {ALPHA_OPAQUE,
                              blend_chan(a_src[23:16], a_dst[23:16], alpha),
                              blend_chan(a_src[15:8],  a_dst[15:8],  alpha),
                              blend_chan(a_src[7:0],   a_dst[7:0],   alpha)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (take)
            valid_reg <= 1'b1;
        else if (!out_stall)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            we_reg    <= a_ctl.we;
            addr_reg  <= addr_next;
            color_reg <= color_next;
            last_reg  <= a_ctl.last;
        end
    end

    assign out_valid    = valid_reg;
    assign write_enable = we_reg;
    assign dest_address = addr_reg;
    assign out_color    = color_reg;
    assign last         = last_reg;

endmodule
`default_nettype wire

/* sv/clipped_alpha_sprite_blit_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clipped_alpha_sprite_blit_top
// Clipped ARGB8888 alpha sprite blitter, one pixel per clock while the output is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one sprite pixel per transfer
//   in raster order, with the framebuffer pixel already at its position.
//   Output channel (out_valid / out_stall) gives exactly one result per input
//   transfer: write enable, linear address, blended color and end of sprite.
//   Config port: cfg_write with cfg_index/cfg_data writes one register per
//   clock; write only while no pixel is in flight.
// Timing:
//   Two register stages (clip register, then output register). A pixel
//   passes through the clip register, then the output register. Throughput
//   is one pixel per clock while out_stall is low, set by the combinational
//   blend/address stage. When the receiver stalls, the output holds; if the
//   clip register is empty, one more pixel is taken into it, then in_stall rises.
// Reset:
//   Asynchronous, active low. Registers return to 1280x720 screen, 32x32
//   sprite at (0,0); column/row counters and both stage valids clear.
// ----------------------------------------------------------------------------
module clipped_alpha_sprite_blit_top #(
    parameter int MAX_SCREEN_DIM = csab_pkg::SCREEN_DIM_DEF,
    parameter int MAX_SPRITE_DIM = csab_pkg::SPRITE_DIM_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // config write port
    input  wire logic                           cfg_write,
    input  wire logic [csab_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [csab_pkg::CFG_DAT_W-1:0] cfg_data,
    // pixel input channel
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [csab_pkg::COLOR_W-1:0]   sprite_pixel,
    input  wire logic [csab_pkg::COLOR_W-1:0]   frame_pixel,
    // result channel
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic                                write_enable,
    output logic [csab_pkg::ADDR_W-1:0]         dest_address,
    output logic [csab_pkg::COLOR_W-1:0]        out_color,
    output logic                                last
);
    import csab_pkg::*;

    localparam int COORD_W = $clog2(MAX_SCREEN_DIM);
    localparam int DIM_W   = $clog2(MAX_SCREEN_DIM + 1);

    // Configuration registers
    logic [SCR_CFG_W-1:0]    screen_width_reg;
    logic [SCR_CFG_W-1:0]    screen_height_reg;
    logic [SPR_CFG_W-1:0]    sprite_width_reg;
    logic [SPR_CFG_W-1:0]    sprite_height_reg;
    logic signed [POS_W-1:0] pos_x_reg;
    logic signed [POS_W-1:0] pos_y_reg;

    // Stage handshake
    logic   in_accept;
    logic   take;
    ctl_t   a_ctl;

    // Clip-stage payload
    logic [COORD_W-1:0] a_x;
    logic [COORD_W-1:0] a_y;
    logic [DIM_W-1:0]   a_scw;
    logic [COLOR_W-1:0] a_src;
    logic [COLOR_W-1:0] a_dst;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= SCREEN_WIDTH_RST;
            screen_height_reg <= SCREEN_HEIGHT_RST;
            sprite_width_reg  <= SPRITE_WIDTH_RST;
            sprite_height_reg <= SPRITE_HEIGHT_RST;
            pos_x_reg         <= POS_RST;
            pos_y_reg         <= POS_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data;
                CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_data;
                CFG_SPRITE_WIDTH:  sprite_width_reg  <= cfg_data[SPR_CFG_W-1:0];
                CFG_SPRITE_HEIGHT: sprite_height_reg <= cfg_data[SPR_CFG_W-1:0];
                CFG_POS_X:         pos_x_reg         <= cfg_data;
                CFG_POS_Y:         pos_y_reg         <= cfg_data;
                default:           ; // unused indexes are ignored
            endcase
        end
    end

    // The clip register is free when empty or when it hands off this cycle.
    assign in_stall  = a_ctl.valid && !take;
    assign in_accept = in_valid && !in_stall;

    csab_clip #(
        .MAX_SCREEN_DIM (MAX_SCREEN_DIM),
        .MAX_SPRITE_DIM (MAX_SPRITE_DIM)
    ) u_clip (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (in_accept),
        .take          (take),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .sprite_width  (sprite_width_reg),
        .sprite_height (sprite_height_reg),
        .pos_x         (pos_x_reg),
        .pos_y         (pos_y_reg),
        .sprite_pixel  (sprite_pixel),
        .frame_pixel   (frame_pixel),
        .a_ctl         (a_ctl),
        .a_x           (a_x),
        .a_y           (a_y),
        .a_scw         (a_scw),
        .a_src         (a_src),
        .a_dst         (a_dst)
    );

    csab_blend #(
        .MAX_SCREEN_DIM (MAX_SCREEN_DIM)
    ) u_blend (
        .clk          (clk),
        .rst_n        (rst_n),
        .a_ctl        (a_ctl),
        .a_x          (a_x),
        .a_y          (a_y),
        .a_scw        (a_scw),
        .a_src        (a_src),
        .a_dst        (a_dst),
        .out_stall    (out_stall),
        .take         (take),
        .out_valid    (out_valid),
        .write_enable (write_enable),
        .dest_address (dest_address),
        .out_color    (out_color),
        .last         (last)
    );

endmodule
`default_nettype wire

/* sv/csab_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csab_checker
// Port-level checks for the sprite blitter, bound to the top level.
// ----------------------------------------------------------------------------
module csab_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_stall,
    input wire logic                         out_valid,
    input wire logic                         out_stall,
    input wire logic                         write_enable,
    input wire logic [csab_pkg::ADDR_W-1:0]  dest_address,
    input wire logic [csab_pkg::COLOR_W-1:0] out_color
);
    import csab_pkg::*;

    // Held result stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped while stalled");

    // Held result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(dest_address) && $stable(out_color))
        else $error("result changed while stalled");

    // Input backs up only behind a stalled, full output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with output free");

    // A skipped pixel carries zero address and color
    a_nowrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !write_enable |-> dest_address == '0 && out_color == '0)
        else $error("non-write result not zeroed");

    // A written pixel never has alpha zero
    a_write_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && write_enable |-> out_color[31:24] != ALPHA_ZERO)
        else $error("write with zero alpha");

endmodule

bind clipped_alpha_sprite_blit_top csab_checker u_csab_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .write_enable (write_enable),
    .dest_address (dest_address),
    .out_color    (out_color)
);
`default_nettype wire
